// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the tangent unit.
// Depends on signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== hdl/tfp_pkg.sv =====
// Types and constants of the triangle tangent unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tfp_pkg;

  localparam logic [31:0] RESET_INV_SPAN        = 32'd65536;
  localparam logic [30:0] RESET_SMALL_THRESHOLD = 31'd107374;
  localparam int          Q_W                   = 15;
  localparam logic [Q_W-1:0] ONE_Q14            = 15'd16384;

  typedef enum logic [1:0] {
    REG_INV_SPAN_X      = 2'd0,
    REG_INV_SPAN_Y      = 2'd1,
    REG_SMALL_THRESHOLD = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
  } triangle_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               uv_degenerate;
    logic               zero_length;
  } result_t;

  // Unnormalized tangent with the determinant flags.
  typedef struct packed {
    logic signed [35:0] tx;
    logic signed [35:0] ty;
    logic signed [35:0] tz;
    logic               degen;
    logic               flip;
  } tvec_t;

  typedef struct packed {
    logic degen;
    logic zero;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } side_t;

  // Normalized magnitudes that ride along the square root pipeline.
  typedef struct packed {
    logic [30:0] m0;
    logic [30:0] m1;
    logic [30:0] m2;
    side_t       side;
  } sqtag_t;

endpackage
`default_nettype wire

// ===== hdl/triangle_tangent_from_planar_uv_unit.sv =====
// Triangle tangent unit: one word in, one word out; a triangle passes the front,
// norm, square root and divider pipelines and the output register in turn.
// Throughput is one triangle per clock outside reset; the 16-stage square root and the
// 8-stage component divider are fully pipelined and set the depth.
// rst is synchronous: it clears the pipeline valid bits, loads register
// defaults, and holds busy high. The result strobe done cannot be stalled.
`default_nettype none
`include "assert_macros.svh"
module triangle_tangent_from_planar_uv_unit import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  triangle_t   triangle,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  logic [31:0] inv_span_x;
  logic [31:0] inv_span_y;
  logic [30:0] small_threshold;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_span_x      <= RESET_INV_SPAN;
      inv_span_y      <= RESET_INV_SPAN;
      small_threshold <= RESET_SMALL_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_INV_SPAN_X:      inv_span_x      <= cfg_data;
        REG_INV_SPAN_Y:      inv_span_y      <= cfg_data;
        REG_SMALL_THRESHOLD: small_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a word is taken every cycle out of reset.
  assign busy = rst;

  logic        f_valid;
  tvec_t       tvec;
  logic        n_valid;
  logic [63:0] sum;
  sqtag_t      n_tag;
  logic        s_valid;
  logic [31:0] len;
  sqtag_t      s_tag;
  logic        d_valid;
  logic [2:0][Q_W-1:0] quot;
  side_t       side;

  // Edges, UV deltas, the determinant test and the raw tangent vector.
  tfp_front u_front (
    .clk, .rst,
    .in_valid(start && !busy),
    .item(triangle),
    .inv_span_x, .inv_span_y, .small_threshold,
    .out_valid(f_valid),
    .tvec
  );

  // Magnitudes are shifted so the largest sits in [2^30, 2^31), then squared.
  tfp_norm u_norm (
    .clk, .rst,
    .in_valid(f_valid),
    .tvec,
    .out_valid(n_valid),
    .sum,
    .tag(n_tag)
  );

  // Length of the scaled vector.
  tfp_sqrt u_sqrt (
    .clk, .rst,
    .in_valid(n_valid),
    .radicand(sum),
    .in_tag(n_tag),
    .out_valid(s_valid),
    .root(len),
    .out_tag(s_tag)
  );

  // Each component becomes round-half-up(m * 16384 / len).
  tfp_div u_div (
    .clk, .rst,
    .in_valid(s_valid),
    .len,
    .in_tag(s_tag),
    .out_valid(d_valid),
    .quot,
    .side
  );

  logic [Q_W-1:0]     qc [3];
  logic signed [15:0] comp [3];
  logic [2:0]         negs;

  assign negs = {side.neg_x, side.neg_y, side.neg_z};

  // Clamp to one, apply the sign, and force zero for a vanishing vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (quot[i] > ONE_Q14) ? ONE_Q14 : quot[i];
      if (side.zero) begin
        comp[i] = '0;
      end else if (negs[2-i]) begin
        comp[i] = -$signed({1'b0, qc[i]});
      end else begin
        comp[i] = $signed({1'b0, qc[i]});
      end
    end
  end

  // Output register: the word is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
    result.tangent_x     <= comp[0];
    result.tangent_y     <= comp[1];
    result.tangent_z     <= comp[2];
    result.uv_degenerate <= side.degen;
    result.zero_length   <= side.zero;
  end

  // A flagged vanishing vector must come out as all zeros.
  `ASSERT_IMPLIES(a_zero_out, done && result.zero_length, result.tangent_x == 16'sd0 && result.tangent_y == 16'sd0 && result.tangent_z == 16'sd0)
  // A normalized vector always keeps at least one nonzero component.
  `ASSERT_IMPLIES(a_nonzero_out, done && !result.zero_length, result.tangent_x != 16'sd0 || result.tangent_y != 16'sd0 || result.tangent_z != 16'sd0)
  // The x and z components never leave the unit range of Q1.14.
  `ASSERT_IMPLIES(a_range, done, result.tangent_x <= 16'sd16384 && result.tangent_x >= -16'sd16384 && result.tangent_z <= 16'sd16384 && result.tangent_z >= -16'sd16384)

endmodule
`default_nettype wire

// ===== hdl/tfp_front.sv =====
// Front pipeline: edges, UV deltas, products, tangent vector and determinant test.
// Depends on tfp_pkg.
`default_nettype none
module tfp_front import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  triangle_t   item,
  input  logic [31:0] inv_span_x,
  input  logic [31:0] inv_span_y,
  input  logic [30:0] small_threshold,
  output logic        out_valid,
  output tvec_t       tvec
);

  // UV delta: edge times reciprocal span, rounded to Q2.30 and saturated.
  function automatic logic signed [31:0] uv_delta(input logic signed [32:0] e,
                                                  input logic [31:0] span);
    logic [32:0] mag;
    logic [63:0] p;
    logic [63:0] r;
    logic [30:0] s;
    mag = e[32] ? 33'(-e) : 33'(e);
    p   = 64'(mag) * 64'(span);
    r   = (p + 64'd2) >> 2;
    s   = (r > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : r[30:0];
    return e[32] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  // Q2.30 delta times Q16.16 edge, rounded half away from zero to Q16.16.
  function automatic logic signed [34:0] t_prod(input logic signed [31:0] d,
                                                input logic signed [32:0] e);
    logic [30:0] dm;
    logic [32:0] em;
    logic [63:0] p;
    logic [63:0] r;
    dm = d[31] ? 31'(-d) : d[30:0];
    em = e[32] ? 33'(-e) : 33'(e);
    p  = 64'(dm) * 64'(em);
    r  = (p + 64'h2000_0000) >> 30;
    return (d[31] ^ e[32]) ? -$signed(35'(r)) : $signed(35'(r));
  endfunction

  logic signed [31:0] v [9];
  logic signed [32:0] e1_a [3];
  logic signed [32:0] e2_a [3];
  logic signed [32:0] e1_b [3];
  logic signed [32:0] e2_b [3];
  logic signed [31:0] du1, dv1, du2, dv2;
  logic signed [63:0] fp1, fp2;
  logic signed [34:0] pa [3];
  logic signed [34:0] pb [3];
  logic [3:0]         vld;
  logic signed [63:0] f;
  logic [63:0]        fmag;
  logic [63:0]        thr;
  logic               degen;

  assign v[0] = item.v0_x;
  assign v[1] = item.v0_y;
  assign v[2] = item.v0_z;
  assign v[3] = item.v1_x;
  assign v[4] = item.v1_y;
  assign v[5] = item.v1_z;
  assign v[6] = item.v2_x;
  assign v[7] = item.v2_y;
  assign v[8] = item.v2_z;

  assign f     = fp1 - fp2;
  assign fmag  = f[63] ? 64'(-f) : 64'(f);
  assign thr   = {33'd0, small_threshold} << 30;
  assign degen = (f == 64'sd0) || (fmag < thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
    for (int i = 0; i < 3; i++) begin
      e1_a[i] <= 33'(v[3+i]) - 33'(v[i]);
      e2_a[i] <= 33'(v[6+i]) - 33'(v[i]);
      e1_b[i] <= e1_a[i];
      e2_b[i] <= e2_a[i];
      pa[i]   <= t_prod(dv2, e1_b[i]);
      pb[i]   <= t_prod(dv1, e2_b[i]);
    end
    du1 <= uv_delta(e1_a[0], inv_span_x);
    dv1 <= uv_delta(e1_a[1], inv_span_y);
    du2 <= uv_delta(e2_a[0], inv_span_x);
    dv2 <= uv_delta(e2_a[1], inv_span_y);
    fp1 <= du1 * dv2;
    fp2 <= du2 * dv1;
    tvec.tx    <= 36'(pa[0]) - 36'(pb[0]);
    tvec.ty    <= 36'(pa[1]) - 36'(pb[1]);
    tvec.tz    <= 36'(pa[2]) - 36'(pb[2]);
    tvec.degen <= degen;
    tvec.flip  <= !degen && f[63];
  end

  assign out_valid = vld[3];

endmodule
`default_nettype wire

// ===== hdl/tfp_norm.sv =====
// Magnitude scaling: common shift of the components and the sum of their squares.
// Depends on tfp_pkg.
`default_nettype none
module tfp_norm import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  tvec_t       tvec,
  output logic        out_valid,
  output logic [63:0] sum,
  output sqtag_t      tag
);

  logic signed [35:0] tt [3];
  logic [34:0]        mg [3];
  logic [34:0]        mx;
  logic [34:0]        m1 [3];
  logic [34:0]        mx1;
  side_t              side1, side2, side3, side4;
  logic [5:0]         pos;
  logic [5:0]         pos2;
  logic [34:0]        m2 [3];
  logic [30:0]        m3 [3];
  logic [30:0]        m4 [3];
  logic [61:0]        sq4 [3];
  logic [4:0]         vld;

  assign tt[0] = tvec.tx;
  assign tt[1] = tvec.ty;
  assign tt[2] = tvec.tz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i] = tt[i][35] ? 35'(-tt[i]) : 35'(tt[i]);
    end
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
  end

  // Leading one of the largest magnitude.
  always_comb begin
    pos = '0;
    for (int i = 0; i < 35; i++) begin
      if (mx1[i]) pos = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
    mx1         <= mx;
    side1.degen <= tvec.degen;
    side1.zero  <= (mx == 35'd0);
    side1.neg_x <= tt[0][35] ^ tvec.flip;
    side1.neg_y <= tt[1][35] ^ tvec.flip;
    side1.neg_z <= tt[2][35] ^ tvec.flip;
    pos2  <= pos;
    side2 <= side1;
    side3 <= side2;
    side4 <= side3;
    for (int i = 0; i < 3; i++) begin
      m1[i]  <= mg[i];
      m2[i]  <= m1[i];
      m3[i]  <= (pos2 > 6'd30) ? 31'(m2[i] >> (pos2 - 6'd30))
                               : 31'(m2[i] << (6'd30 - pos2));
      m4[i]  <= m3[i];
      sq4[i] <= 62'(m3[i]) * 62'(m3[i]);
    end
    sum      <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
    tag.m0   <= m4[0];
    tag.m1   <= m4[1];
    tag.m2   <= m4[2];
    tag.side <= side4;
  end

  assign out_valid = vld[4];

endmodule
`default_nettype wire

// ===== hdl/tfp_sqrt.sv =====
// Pipelined floor integer square root of a 64-bit value, two result bits per stage.
// Depends on tfp_pkg.
`default_nettype none
module tfp_sqrt import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  input  sqtag_t      in_tag,
  output logic        out_valid,
  output logic [31:0] root,
  output sqtag_t      out_tag
);

  localparam int STAGES = 16;
  localparam int STEPS  = 2;

  logic [63:0]     xs [STAGES+1];
  logic [63:0]     rs [STAGES+1];
  sqtag_t          tg [STAGES+1];
  logic [STAGES:0] vs;

  assign xs[0] = radicand;
  assign rs[0] = '0;
  assign tg[0] = in_tag;
  assign vs[0] = in_valid;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [63:0] x_n;
    logic [63:0] r_n;
    logic [63:0] b;

    always_comb begin
      x_n = xs[j];
      r_n = rs[j];
      b   = '0;
      for (int s = 0; s < STEPS; s++) begin
        b = 64'd1 << (62 - 2 * (STEPS * j + s));
        if (x_n >= r_n + b) begin
          x_n = x_n - (r_n + b);
          r_n = (r_n >> 1) + b;
        end else begin
          r_n = r_n >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else begin
        vs[j+1] <= vs[j];
      end
      xs[j+1] <= x_n;
      rs[j+1] <= r_n;
      tg[j+1] <= tg[j];
    end
  end

  assign out_valid = vs[STAGES];
  assign root      = rs[STAGES][31:0];
  assign out_tag   = tg[STAGES];

endmodule
`default_nettype wire

// ===== hdl/tfp_div.sv =====
// Pipelined restoring divider for the three components, two quotient bits per stage and one in the last.
// Depends on tfp_pkg.
`default_nettype none
module tfp_div import tfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         len,
  input  sqtag_t              in_tag,
  output logic                out_valid,
  output logic [2:0][Q_W-1:0] quot,
  output side_t               side
);

  localparam int STEPS  = 2;
  localparam int STAGES = (Q_W + STEPS - 1) / STEPS;

  logic [2:0][31:0]    rem [STAGES+1];
  logic [2:0][Q_W-1:0] nlo [STAGES+1];
  logic [2:0][Q_W-1:0] quo [STAGES+1];
  logic [31:0]         ln  [STAGES+1];
  side_t               sd  [STAGES+1];
  logic [STAGES:0]     vs;
  logic [30:0]         mi  [3];
  logic [45:0]         num [3];

  assign mi[0] = in_tag.m0;
  assign mi[1] = in_tag.m1;
  assign mi[2] = in_tag.m2;

  // Numerator m * 16384 + len / 2 for round half up.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]    = {1'b0, mi[i], 14'd0} + 46'(len >> 1);
      rem[0][i] = 32'(num[i] >> Q_W);
      nlo[0][i] = num[i][Q_W-1:0];
      quo[0][i] = '0;
    end
  end

  assign ln[0] = len;
  assign sd[0] = in_tag.side;
  assign vs[0] = in_valid;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [2:0][31:0]    r_n;
    logic [2:0][Q_W-1:0] n_n;
    logic [2:0][Q_W-1:0] q_n;
    logic [32:0]         r33;

    always_comb begin
      r_n = rem[j];
      n_n = nlo[j];
      q_n = quo[j];
      r33 = '0;
      for (int s = 0; s < STEPS; s++) begin
        if (STEPS * j + s < Q_W) begin
          for (int i = 0; i < 3; i++) begin
            r33    = {r_n[i], n_n[i][Q_W-1]};
            n_n[i] = n_n[i] << 1;
            if (r33 >= {1'b0, ln[j]}) begin
              r_n[i] = 32'(r33 - {1'b0, ln[j]});
              q_n[i] = {q_n[i][Q_W-2:0], 1'b1};
            end else begin
              r_n[i] = r33[31:0];
              q_n[i] = {q_n[i][Q_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else begin
        vs[j+1] <= vs[j];
      end
      rem[j+1] <= r_n;
      nlo[j+1] <= n_n;
      quo[j+1] <= q_n;
      ln[j+1]  <= ln[j];
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = vs[STAGES];
  assign quot      = quo[STAGES];
  assign side      = sd[STAGES];

endmodule
`default_nettype wire
